// ===== rtl/cqs_pkg.sv =====
// ----------------------------------------------------------------------------
// cqs_pkg: shared types and constants
// Sizes, operation and status codes, and the request and response structs
// of the pointer unit used by the circular queue with search.
// ----------------------------------------------------------------------------
package cqs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQUEUE = 3'd0,
        KIND_DEQUEUE = 3'd1,
        KIND_PEEK    = 3'd2,
        KIND_SEARCH  = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        PTR_ADVANCE = 1'b0,
        PTR_REDUCE  = 1'b1
    } ptr_op_t;

    typedef struct packed {
        ptr_op_t          op;
        logic [CNT_W-1:0] ptr;
    } ptr_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] result;
        logic             in_range;
    } ptr_rsp_t;

endpackage

// ===== rtl/cqs_in_if.sv =====
// ----------------------------------------------------------------------------
// cqs_in_if: request channel
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
interface cqs_in_if import cqs_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic        [KIND_W-1:0]     kind;
    logic signed [DATA_WIDTH-1:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);

endinterface

// ===== rtl/cqs_out_if.sv =====
// ----------------------------------------------------------------------------
// cqs_out_if: result channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface cqs_out_if import cqs_pkg::*; ();

    logic                         valid;
    logic                         ready;
    logic        [STATUS_W-1:0]   status;
    logic signed [DATA_WIDTH-1:0] data;
    logic        [PTR_W-1:0]      slot;
    logic        [PTR_W-1:0]      position;
    logic        [CNT_W-1:0]      count;
    logic                         is_empty;
    logic                         is_full;

    modport source (output valid, output status, output data, output slot,
                    output position, output count, output is_empty,
                    output is_full, input ready);
    modport sink   (input valid, input status, input data, input slot,
                    input position, input count, input is_empty,
                    input is_full, output ready);

endinterface

// ===== rtl/cqs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cqs_cfg_if: configuration write channel
// Valid/ready channel carrying the capacity register write data.
// ----------------------------------------------------------------------------
interface cqs_cfg_if import cqs_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);

endinterface

// ===== rtl/cqs_ram.sv =====
// ----------------------------------------------------------------------------
// cqs_ram: generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/cqs_ptr_unit.sv =====
// ----------------------------------------------------------------------------
// cqs_ptr_unit: shared pointer arithmetic
// Advances a pointer with wrap at capacity, or does one subtract step of a
// reduction modulo capacity.
// ----------------------------------------------------------------------------
module cqs_ptr_unit import cqs_pkg::*; (
    input  ptr_req_t         req,
    input  logic [CNT_W-1:0] cap,
    output ptr_rsp_t         rsp
);

    logic [CNT_W-1:0] sum;
    logic             below;

    assign sum   = req.ptr + CNT_W'(1);
    assign below = (req.ptr < cap);

    always_comb
    begin
        rsp.in_range = below;
        unique case (req.op)
            PTR_ADVANCE: rsp.result = (sum >= cap) ? '0 : sum;
            PTR_REDUCE:  rsp.result = below ? req.ptr : req.ptr - cap;
            default:     rsp.result = req.ptr;
        endcase
    end

endmodule

// ===== rtl/circular_queue_with_search_unit.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_search_unit: ring-buffer FIFO with linear search
// Sequenced queue of signed words: enqueue, dequeue, peek, search, clear.
// ----------------------------------------------------------------------------
// One request is handled at a time and req.ready is high only while the
// sequencer is idle; a finished result waits in the output register while the
// next request is taken. Dequeue and peek, unless refused on an empty queue,
// do one read of the storage RAM, whose read data is registered. Search first
// reduces the head modulo the capacity by subtract steps (none unless the
// capacity was lowered under the head), then compares the held entries, at
// most 16, one per cycle through the single RAM read port and the shared
// pointer unit. While the previous result still waits unaccepted in the output
// register, the sequencer holds in its done state. Capacity 0 acts as 1 and
// values above 16 act as 16; capacity must be written only while idle, and the
// block itself does not enforce this.
module circular_queue_with_search_unit import cqs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    cqs_in_if.sink    req,
    cqs_out_if.source rsp,
    cqs_cfg_if.sink   cfg
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_RDATA = 6'b000100,
        S_MOD   = 6'b001000,
        S_SCAN  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cap_reg;
    logic [CNT_W-1:0]      cap_eff;
    logic [PTR_W-1:0]      head_reg, head_next;
    logic [PTR_W-1:0]      tail_reg, tail_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [PTR_W-1:0]      scan_ptr_reg, scan_ptr_next;
    logic [PTR_W-1:0]      idx_reg, idx_next;
    kind_t                 kind_reg;
    logic [DATA_WIDTH-1:0] value_reg;
    status_t               res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0] res_data_reg, res_data_next;
    logic [PTR_W-1:0]      res_slot_reg, res_slot_next;
    logic [PTR_W-1:0]      res_pos_reg, res_pos_next;
    logic                  out_valid_reg;

    ptr_req_t              ptr_req;
    ptr_rsp_t              ptr_rsp;
    logic [PTR_W-1:0]      ptr_res;

    logic                  ram_we;
    logic [PTR_W-1:0]      ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic                  accept;
    logic                  out_free;
    logic                  is_full_now;

    assign accept      = req.valid && req.ready;
    assign out_free    = !out_valid_reg || rsp.ready;
    assign req.ready   = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign ptr_res     = ptr_rsp.result[PTR_W-1:0];
    assign is_full_now = (fill_reg >= cap_eff);

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CNT_W'(1);
        end
        else if (cap_reg > CNT_W'(DEPTH))
        begin
            cap_eff = CNT_W'(DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    cqs_ptr_unit u_ptr (
        .req (ptr_req),
        .cap (cap_eff),
        .rsp (ptr_rsp)
    );

    cqs_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_storage (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (value_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // pointer unit and RAM read address, steered by the sequencer
    always_comb
    begin
        ptr_req.op  = PTR_ADVANCE;
        ptr_req.ptr = {1'b0, head_reg};
        ram_raddr   = head_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                ptr_req.ptr = {1'b0, tail_reg};
            end
            S_MOD:
            begin
                ptr_req.op  = PTR_REDUCE;
                ptr_req.ptr = {1'b0, scan_ptr_reg};
                ram_raddr   = scan_ptr_reg;
            end
            S_SCAN:
            begin
                ptr_req.ptr = {1'b0, scan_ptr_reg};
                ram_raddr   = ptr_res;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        scan_ptr_next   = scan_ptr_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_slot_next   = res_slot_reg;
        res_pos_next    = res_pos_reg;
        ram_we          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = ST_OK;
                    res_data_next   = '0;
                    res_slot_next   = '0;
                    res_pos_next    = '0;
                    state_next      = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (kind_reg) inside
                    KIND_ENQUEUE:
                    begin
                        if (is_full_now)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            tail_next = ptr_res;
                            fill_next = fill_reg + CNT_W'(1);
                        end
                    end
                    KIND_DEQUEUE, KIND_PEEK:
                    begin
                        if (fill_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            state_next = S_RDATA;
                        end
                    end
                    KIND_SEARCH:
                    begin
                        res_status_next = ST_NOT_FOUND;
                        if (fill_reg != '0)
                        begin
                            scan_ptr_next = head_reg;
                            idx_next      = '0;
                            state_next    = S_MOD;
                        end
                    end
                    KIND_CLEAR:
                    begin
                        head_next = '0;
                        tail_next = '0;
                        fill_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RDATA:
            begin
                res_data_next = ram_rdata;
                if (kind_reg == KIND_DEQUEUE)
                begin
                    head_next = ptr_res;
                    fill_next = fill_reg - CNT_W'(1);
                end
                state_next = S_DONE;
            end
            S_MOD:
            begin
                // head mod capacity, one subtract per cycle
                if (ptr_rsp.in_range)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    scan_ptr_next = ptr_res;
                end
            end
            S_SCAN:
            begin
                if (ram_rdata == value_reg)
                begin
                    res_status_next = ST_OK;
                    res_slot_next   = scan_ptr_reg;
                    res_pos_next    = idx_reg;
                    state_next      = S_DONE;
                end
                else if ({1'b0, idx_reg} + CNT_W'(1) == fill_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    scan_ptr_next = ptr_res;
                    idx_next      = idx_reg + PTR_W'(1);
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            cap_reg       <= CNT_W'(DEPTH);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            if (cfg.valid && cfg.ready)
            begin
                cap_reg <= cfg.capacity;
            end
            if (state_reg == S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind_t'(req.kind);
            value_reg <= req.value;
        end
        scan_ptr_reg   <= scan_ptr_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_slot_reg   <= res_slot_next;
        res_pos_reg    <= res_pos_next;
        if (state_reg == S_DONE && out_free)
        begin
            rsp.status   <= res_status_reg;
            rsp.data     <= res_data_reg;
            rsp.slot     <= res_slot_reg;
            rsp.position <= res_pos_reg;
            rsp.count    <= fill_reg;
            rsp.is_empty <= (fill_reg == '0);
            rsp.is_full  <= is_full_now;
        end
    end

    assign rsp.valid = out_valid_reg;

    // never more entries than slots
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // a result appears only when the sequencer finishes an operation
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result without finished operation");

    // the scan stays inside the held entries and the capacity window
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
            ({1'b0, idx_reg} < fill_reg) && ({1'b0, scan_ptr_reg} < cap_eff))
        else $error("search scan out of range");

    // a refused enqueue leaves the queue untouched
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && kind_reg == KIND_ENQUEUE && is_full_now) |=>
            $stable(fill_reg) && $stable(tail_reg))
        else $error("full enqueue changed the queue");

endmodule

// ===== bench/circular_queue_with_search_unit_test.sv =====
// ----------------------------------------------------------------------------
// circular_queue_with_search_unit_test: self-checking bench for the queue
// Walks a short table of directed requests, then runs phases of random
// enqueue/dequeue/peek/search/clear traffic under a sweep of capacity
// settings. Each response is checked against the table or a behavioral
// queue model kept in the bench. Both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module circular_queue_with_search_unit_test import cqs_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 12;
    localparam int PHASE_REQS     = 75;
    localparam int MAX_REPORTS    = 10;

    // kind codes that the block treats as no-ops
    localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    typedef struct packed {
        status_t               status;
        logic [DATA_WIDTH-1:0] data;
        logic [PTR_W-1:0]      slot;
        logic [PTR_W-1:0]      position;
        logic [CNT_W-1:0]      count;
        logic                  is_empty;
        logic                  is_full;
    } qres_t;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [DATA_WIDTH-1:0] value;
        logic                  typed;
        qres_t                 want;
    } dir_row_t;

    localparam qres_t R_NONE = '0;
    localparam qres_t R_EMPTY = '{status: ST_EMPTY, data: '0, slot: '0,
        position: '0, count: '0, is_empty: 1'b1, is_full: 1'b0};
    localparam qres_t R_MISS_EMPTY = '{status: ST_NOT_FOUND, data: '0, slot: '0,
        position: '0, count: '0, is_empty: 1'b1, is_full: 1'b0};
    localparam qres_t R_IDLE_EMPTY = '{status: ST_OK, data: '0, slot: '0,
        position: '0, count: '0, is_empty: 1'b1, is_full: 1'b0};
    localparam qres_t R_REFUSED_FULL = '{status: ST_FULL, data: '0, slot: '0,
        position: '0, count: 5'd16, is_empty: 1'b0, is_full: 1'b1};
    localparam qres_t R_MISS_FULL = '{status: ST_NOT_FOUND, data: '0, slot: '0,
        position: '0, count: 5'd16, is_empty: 1'b0, is_full: 1'b1};

    // Empty-queue cases first, then sixteen enqueues so every slot holds a
    // written word before anything can read it.
    localparam dir_row_t DIRECTED [27] = '{
        '{KIND_DEQUEUE,    32'h0000_0000, 1'b1, R_EMPTY},
        '{KIND_PEEK,       32'hFFFF_FFFF, 1'b1, R_EMPTY},
        '{KIND_SEARCH,     32'h0000_0000, 1'b1, R_MISS_EMPTY},
        '{KIND_UNUSED_LO,  32'h7FFF_FFFF, 1'b1, R_IDLE_EMPTY},
        '{KIND_UNUSED_HI,  32'h8000_0000, 1'b1, R_IDLE_EMPTY},
        '{KIND_ENQUEUE,    32'h7FFF_FFFF, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h8000_0000, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'hFFFF_FFFF, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h0000_0000, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h0000_0001, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h8000_0000, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h5555_5555, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'hAAAA_AAAA, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h7FFF_FFFE, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h8000_0001, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h0000_000C, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h0000_000D, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h0F0F_0F0F, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'hF0F0_F0F0, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h0000_0002, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'hFFFF_FFFE, 1'b0, R_NONE},
        '{KIND_ENQUEUE,    32'h0BAD_F00D, 1'b1, R_REFUSED_FULL},
        '{KIND_PEEK,       32'h0000_0000, 1'b0, R_NONE},
        '{KIND_SEARCH,     32'h8000_0000, 1'b0, R_NONE},
        '{KIND_SEARCH,     32'h1234_5678, 1'b1, R_MISS_FULL},
        '{KIND_DEQUEUE,    32'h0000_0000, 1'b0, R_NONE},
        '{KIND_CLEAR,      32'h0000_0000, 1'b1, R_IDLE_EMPTY}
    };

    logic clk = 1'b0;
    logic rst_n;

    cqs_in_if  req_ch ();
    cqs_out_if rsp_ch ();
    cqs_cfg_if cfg_ch ();

    circular_queue_with_search_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // bench copy of the queue
    logic [DATA_WIDTH-1:0] q_mem [DEPTH];
    int                    q_head = 0;
    int                    q_tail = 0;
    int                    q_fill = 0;
    logic [CNT_W-1:0]      q_cap  = 5'd16;

    qres_t pending_results [$];

    int errors       = 0;
    int requests     = 0;
    int cap_writes   = 0;
    int search_hits  = 0;
    int search_miss  = 0;
    int full_refused = 0;
    int empty_refused = 0;
    int holds_asked  = 0;
    bit src_calm     = 1'b0;

    function automatic int live_capacity();
        if (q_cap == 0)
            return 1;
        if (q_cap > DEPTH)
            return DEPTH;
        return int'(q_cap);
    endfunction

    function automatic int next_slot(input int p, input int cap);
        return (p + 1 >= cap) ? 0 : p + 1;
    endfunction

    function automatic qres_t predict_queue_op(input logic [KIND_W-1:0] kind,
                                               input logic [DATA_WIDTH-1:0] word);
        int    cap;
        int    s;
        qres_t r;
        cap = live_capacity();
        r = '0;
        r.status = ST_OK;
        case (kind)
            KIND_ENQUEUE:
                if (q_fill >= cap)
                    r.status = ST_FULL;
                else
                begin
                    q_mem[q_tail] = word;
                    q_tail = next_slot(q_tail, cap);
                    q_fill++;
                end
            KIND_DEQUEUE:
                if (q_fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.data = q_mem[q_head];
                    q_head = next_slot(q_head, cap);
                    q_fill--;
                end
            KIND_PEEK:
                if (q_fill == 0)
                    r.status = ST_EMPTY;
                else
                    r.data = q_mem[q_head];
            KIND_SEARCH:
            begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < q_fill; i++)
                begin
                    s = (q_head + i) % cap;
                    if (q_mem[s] == word)
                    begin
                        r.status = ST_OK;
                        r.slot = PTR_W'(s);
                        r.position = PTR_W'(i);
                        break;
                    end
                end
            end
            KIND_CLEAR:
            begin
                q_head = 0;
                q_tail = 0;
                q_fill = 0;
            end
            default: ;
        endcase
        r.count = CNT_W'(q_fill);
        r.is_empty = (q_fill == 0);
        r.is_full = (q_fill >= cap);
        return r;
    endfunction

    // mostly zero, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] rand_word();
        case ($urandom_range(0, 9)) inside
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3, 4: return DATA_WIDTH'($urandom_range(0, 3));
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    task automatic note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic send_op(input logic [KIND_W-1:0] kind,
                           input logic [DATA_WIDTH-1:0] word,
                           input logic typed, input qres_t want, input int gap);
        qres_t got;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= word;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        got = predict_queue_op(kind, word);
        pending_results.push_back(typed ? want : got);
        requests++;
        case (got.status)
            ST_FULL:  full_refused++;
            ST_EMPTY: empty_refused++;
            ST_NOT_FOUND: search_miss++;
            default: if (kind == KIND_SEARCH) search_hits++;
        endcase
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] cap);
        cfg_ch.capacity <= cap;
        cfg_ch.valid    <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        q_cap = cap;
        cap_writes++;
    endtask

    // response side: check, then decide ready for the next cycle
    always @(posedge clk)
    begin : rsp_side
        static int hold_left  = 0;
        static int stall_left = 0;
        static int holds_done = 0;
        static int cycle      = 0;
        static bit calm       = 1'b0;
        qres_t seen;
        qres_t want;

        if (rsp_ch.valid && rsp_ch.ready)
        begin
            seen = '{status: status_t'(rsp_ch.status), data: rsp_ch.data,
                     slot: rsp_ch.slot, position: rsp_ch.position,
                     count: rsp_ch.count, is_empty: rsp_ch.is_empty,
                     is_full: rsp_ch.is_full};
            if (pending_results.size() == 0)
                note_error($sformatf("response with no request pending: status %0d",
                                     seen.status));
            else
            begin
                want = pending_results.pop_front();
                if (seen.status !== want.status || seen.data !== want.data ||
                    seen.slot !== want.slot || seen.position !== want.position ||
                    seen.count !== want.count || seen.is_empty !== want.is_empty ||
                    seen.is_full !== want.is_full)
                    note_error($sformatf({"exp st=%0d d=%0d slot=%0d pos=%0d cnt=%0d ",
                        "e=%b f=%b / got st=%0d d=%0d slot=%0d pos=%0d cnt=%0d e=%b f=%b"},
                        want.status, $signed(want.data), want.slot, want.position,
                        want.count, want.is_empty, want.is_full,
                        seen.status, $signed(seen.data), seen.slot, seen.position,
                        seen.count, seen.is_empty, seen.is_full));
            end
        end

        cycle++;
        if (cycle % 128 == 0)
            calm = ($urandom_range(0, 3) == 0);

        if (hold_left > 0)
        begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
        end
        else if (holds_done != holds_asked)
        begin
            holds_done++;
            hold_left = HOLD_CYCLES - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) < 3)
                stall_left = idle_len();
        end
    end

    always @(posedge clk)
    begin : watchdog
        static int quiet = 0;
        if (rst_n === 1'b1)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d responses pending",
                         quiet, pending_results.size());
                $display("circular_queue_with_search_unit_test: done, errors");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        logic [CNT_W-1:0]      cap_plan [PHASES];
        logic [KIND_W-1:0]     kind;
        logic [DATA_WIDTH-1:0] word;
        int                    r;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.kind     <= KIND_PEEK;
        req_ch.value    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.capacity <= 5'd16;

        // extremes and out-of-range settings first, then random ones
        cap_plan = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd8, 5'd16,
                     5'd0, 5'd0, 5'd0, 5'd0};
        for (int p = 8; p < PHASES; p++)
            cap_plan[p] = CNT_W'($urandom_range(0, 31));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_capacity(5'd16);

        foreach (DIRECTED[i])
            send_op(DIRECTED[i].kind, DIRECTED[i].value, DIRECTED[i].typed,
                    DIRECTED[i].want, idle_len());

        // capacity changes happen with whatever the queue holds at that point
        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            write_capacity(cap_plan[ph]);
            src_calm = (ph % 4 == 2) || (ph == 3);
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                if (ph == 3 && n == 10)
                    holds_asked++;
                if (ph == 6 && n == PHASE_REQS / 2)
                    wait_drained();
                r = $urandom_range(0, 99);
                word = rand_word();
                if (r < 36)
                    kind = KIND_ENQUEUE;
                else if (r < 60)
                    kind = KIND_DEQUEUE;
                else if (r < 70)
                    kind = KIND_PEEK;
                else if (r < 94)
                begin
                    kind = KIND_SEARCH;
                    // mostly look for something that is held
                    if (q_fill > 0 && $urandom_range(0, 3) != 0)
                        word = q_mem[(q_head + $urandom_range(0, q_fill - 1))
                                     % live_capacity()];
                end
                else if (r < 97)
                    kind = KIND_CLEAR;
                else
                    kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                send_op(kind, word, 1'b0, R_NONE, src_calm ? 0 : idle_len());
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
            note_error($sformatf("%0d responses never arrived", pending_results.size()));

        $display("covered %0d requests over %0d capacity writes (incl. 0, 1, 16, 17, 31)",
                 requests, cap_writes);
        $display("search hits %0d, misses %0d; full refusals %0d, empty refusals %0d",
                 search_hits, search_miss, full_refused, empty_refused);
        if (errors == 0)
            $display("circular_queue_with_search_unit_test: done, clean");
        else
            $display("circular_queue_with_search_unit_test: done, errors");
        $finish;
    end

endmodule

// ===== circular_queue_with_search_unit.f =====
rtl/cqs_pkg.sv
rtl/cqs_in_if.sv
rtl/cqs_out_if.sv
rtl/cqs_cfg_if.sv
rtl/cqs_ram.sv
rtl/cqs_ptr_unit.sv
rtl/circular_queue_with_search_unit.sv
bench/circular_queue_with_search_unit_test.sv
